// ===== rtl/pcfc_pkg.sv =====
// shared types, constants and the cordic angle table for the fov crop block
// no dependencies
`default_nettype none

package pcfc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;

  localparam logic KIND_POSE  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_FOV_H = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOV_UP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOV_DOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFFSET = 3'd5;

  localparam logic [15:0] HALF_FOV_H_RST = 16'd10923;
  localparam logic signed [15:0] FOV_UP_RST   = 16'sd3186;
  localparam logic signed [15:0] FOV_DOWN_RST = -16'sd3186;
  localparam logic [30:0] MIN_RANGE_RST = 31'd0;
  localparam logic [30:0] MAX_RANGE_RST = 31'd1966080;
  localparam logic signed [15:0] YAW_OFFSET_RST = 16'sd0;

  localparam logic signed [15:0] ROT_ONE = 16'sd16384;
  localparam logic [19:0] INV_GAIN_Q20 = 20'd636750;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [15:0]        half_fov_h;
    logic signed [15:0] fov_up;
    logic signed [15:0] elev_lo;
    logic [30:0]        range_lo;
    logic [30:0]        range_hi;
    logic signed [15:0] az_center;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               finite;
    logic               last;
    logic [9*16-1:0]    rot;
  } item_t;

  function automatic logic [31:0] atan_step(input int idx, input int ab);
    logic [31:0] e;
    logic [32:0] t;
    case (idx)
      0:  e = 32'd536870912;
      1:  e = 32'd316933406;
      2:  e = 32'd167458907;
      3:  e = 32'd85004756;
      4:  e = 32'd42667331;
      5:  e = 32'd21354465;
      6:  e = 32'd10679838;
      7:  e = 32'd5340245;
      8:  e = 32'd2670163;
      9:  e = 32'd1335087;
      10: e = 32'd667544;
      11: e = 32'd333772;
      12: e = 32'd166886;
      13: e = 32'd83443;
      14: e = 32'd41722;
      15: e = 32'd20861;
      16: e = 32'd10430;
      17: e = 32'd5215;
      18: e = 32'd2608;
      19: e = 32'd1304;
      20: e = 32'd652;
      21: e = 32'd326;
      22: e = 32'd163;
      23: e = 32'd81;
      default: e = 32'd0;
    endcase
    t = {1'b0, e} + (33'd1 << (31 - ab));
    return 32'(t >> (32 - ab));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pcfc_cordic.sv =====
// pipelined cordic vectoring unit, one stage per iteration, with a side tag
// depends on pcfc_pkg for the angle table
`default_nettype none

module pcfc_cordic
  import pcfc_pkg::*;
#(
  parameter int W      = 40,
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int AB     = ANGLE_BITS_DEF,
  parameter int TW     = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [W-1:0]  in_x,
  input  wire logic signed [W-1:0]  in_y,
  input  wire logic [TW-1:0]        in_tag,
  output logic                      out_valid,
  output logic signed [W-1:0]       out_mag,
  output logic signed [AB+1:0]      out_ang,
  output logic [TW-1:0]             out_tag
);

  localparam int ZW = AB + 2;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << (AB - 1);

  logic signed [W-1:0]  x_r    [STAGES+1];
  logic signed [W-1:0]  y_r    [STAGES+1];
  logic signed [ZW-1:0] z_r    [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic                 v_r    [STAGES+1];
  logic [TW-1:0]        tag_r  [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      tag_r[0]  <= in_tag;
      if (in_x[W-1]) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= HALF_TURN;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(k, AB));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        tag_r[k+1]  <= tag_r[k];
        if (!y_r[k][W-1]) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + STEP;
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - STEP;
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_mag   = x_r[STAGES];
  assign out_ang   = zero_r[STAGES] ? '0 : z_r[STAGES];
  assign out_tag   = tag_r[STAGES];

endmodule

`default_nettype wire

// ===== rtl/pcfc_front.sv =====
// front end: accepts items, builds the body rotation for pose items
// depends on pcfc_pkg for the queue item type
`default_nettype none

module pcfc_front
  import pcfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  input  wire logic               in_point_finite,
  input  wire logic               in_last_in_scan,
  input  wire logic               q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  localparam logic signed [33:0] ONE_Q28 = 34'sd1 <<< 28;

  logic               fs_valid_r;
  logic               fs_kind_r;
  logic signed [31:0] fs_pos_r [3];
  logic               fs_finite_r;
  logic               fs_last_r;
  // xx yy zz xy xz yz xw yw zw
  logic signed [31:0] fs_prod_r [9];
  logic               accept;
  logic signed [33:0] r [9];
  logic signed [33:0] p [9];

  function automatic logic [15:0] rnd_sat(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [19:0] s;
    t = v + 34'sd8192;
    s = t[33:14];
    if (s > 20'sd32767) begin
      return 16'h7fff;
    end else if (s < -20'sd32768) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  assign q_push   = fs_valid_r && !q_full;
  assign in_stall = fs_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_valid_r <= 1'b0;
    end else if (accept) begin
      fs_valid_r <= 1'b1;
    end else if (q_push) begin
      fs_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fs_kind_r    <= in_kind;
      fs_pos_r[0]  <= in_pos_x;
      fs_pos_r[1]  <= in_pos_y;
      fs_pos_r[2]  <= in_pos_z;
      fs_finite_r  <= in_point_finite;
      fs_last_r    <= in_last_in_scan;
      fs_prod_r[0] <= in_quat_x * in_quat_x;
      fs_prod_r[1] <= in_quat_y * in_quat_y;
      fs_prod_r[2] <= in_quat_z * in_quat_z;
      fs_prod_r[3] <= in_quat_x * in_quat_y;
      fs_prod_r[4] <= in_quat_x * in_quat_z;
      fs_prod_r[5] <= in_quat_y * in_quat_z;
      fs_prod_r[6] <= in_quat_x * in_quat_w;
      fs_prod_r[7] <= in_quat_y * in_quat_w;
      fs_prod_r[8] <= in_quat_z * in_quat_w;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = 34'(fs_prod_r[i]);
    end
    r[0] = ONE_Q28 - ((p[1] + p[2]) <<< 1);
    r[1] = (p[3] - p[8]) <<< 1;
    r[2] = (p[4] + p[7]) <<< 1;
    r[3] = (p[3] + p[8]) <<< 1;
    r[4] = ONE_Q28 - ((p[0] + p[2]) <<< 1);
    r[5] = (p[5] - p[6]) <<< 1;
    r[6] = (p[4] - p[7]) <<< 1;
    r[7] = (p[5] + p[6]) <<< 1;
    r[8] = ONE_Q28 - ((p[0] + p[1]) <<< 1);
  end

  // rotation is stored transposed, row-major
  always_comb begin
    q_item.kind   = fs_kind_r;
    q_item.pos_x  = fs_pos_r[0];
    q_item.pos_y  = fs_pos_r[1];
    q_item.pos_z  = fs_pos_r[2];
    q_item.finite = fs_finite_r;
    q_item.last   = fs_last_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q_item.rot[(i*3+j)*16 +: 16] = rnd_sat(r[j*3+i]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcfc_queue.sv =====
// short item queue between the front and back ends
// depends on pcfc_pkg for the item type and depth
`default_nettype none

module pcfc_queue
  import pcfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     push_item,
  input  wire logic pop,
  output item_t     pop_item,
  output logic      full,
  output logic      empty
);

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         mem_r [QDEPTH];
  logic [AW-1:0] wr_r;
  logic [AW-1:0] rd_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcfc_back.sv =====
// back end: pose state, body transform, range test, azimuth and elevation windows
// depends on pcfc_pkg and pcfc_cordic
`default_nettype none

module pcfc_back
  import pcfc_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               q_empty,
  input  item_t                   q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_keep,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    out_scan_end
);

  localparam int CW = 40;
  localparam int ZW = ANGLE_BITS + 2;
  localparam int UP_SH = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam int DN_SH = (ANGLE_BITS > 16) ? (ANGLE_BITS - 16) : 0;
  localparam logic signed [31:0] RND = 32'sd1 <<< DN_SH >>> 1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last;
  } side_t;

  typedef struct packed {
    logic               keep;
    logic signed [36:0] bz;
    side_t              side;
  } tag1_t;

  typedef struct packed {
    logic  keep;
    side_t side;
  } tag2_t;

  function automatic logic signed [15:0] to_bin16(input logic signed [ZW-1:0] z);
    logic signed [31:0] zx;
    logic signed [31:0] a;
    zx = 32'(z);
    a = ((zx + RND) >>> DN_SH) <<< UP_SH;
    return a[15:0];
  endfunction

  logic               adv;
  logic               out_valid_r;

  logic signed [15:0] rot_r [9];
  logic signed [31:0] tr_r [3];

  logic               p0_v_r;
  logic signed [32:0] p0_d_r [3];
  logic signed [15:0] p0_rot_r [9];
  side_t              p0_side_r;
  logic               p0_fin_r;

  logic               p1_v_r;
  logic signed [48:0] p1_prod_r [9];
  side_t              p1_side_r;
  logic               p1_fin_r;

  logic               p2_v_r;
  logic signed [36:0] p2_b_r [3];
  side_t              p2_side_r;
  logic               p2_fin_r;

  logic               p3_v_r;
  logic signed [36:0] p3_b_r [3];
  logic [35:0]        p3_hh_r [3];
  logic [35:0]        p3_hl_r [3];
  logic [35:0]        p3_ll_r [3];
  side_t              p3_side_r;
  logic               p3_fin_r;

  logic               p4_v_r;
  logic signed [36:0] p4_b_r [3];
  logic [73:0]        p4_sq_r;
  side_t              p4_side_r;
  logic               p4_fin_r;

  logic               p5_v_r;
  logic signed [36:0] p5_b_r [3];
  side_t              p5_side_r;
  logic               p5_keep_r;

  logic [61:0]        min2_r;
  logic [61:0]        max2_r;

  logic               c1_v;
  logic signed [CW-1:0] c1_mag;
  logic signed [ZW-1:0] c1_ang;
  logic [$bits(tag1_t)-1:0] c1_tag_in;
  logic [$bits(tag1_t)-1:0] c1_tag_out;
  tag1_t              c1_t;

  logic               p6_v_r;
  logic signed [60:0] p6_mp_r;
  logic signed [36:0] p6_bz_r;
  side_t              p6_side_r;
  logic               p6_keep_r;
  logic signed [36:0] p6_bz_next;
  side_t              p6_side_next;
  logic               p6_keep_next;

  logic               p7_v_r;
  logic signed [CW-1:0] p7_rho_r;
  logic signed [36:0] p7_bz_r;
  side_t              p7_side_r;
  logic               p7_keep_r;

  logic               c2_v;
  logic signed [CW-1:0] c2_mag;
  logic signed [ZW-1:0] c2_ang;
  logic [$bits(tag2_t)-1:0] c2_tag_in;
  logic [$bits(tag2_t)-1:0] c2_tag_out;
  tag2_t              c2_t;

  logic signed [35:0] u [3];
  logic [73:0]        sq_sum;
  logic               range_ok;
  logic signed [15:0] az;
  logic signed [16:0] az_x;
  logic [16:0]        az_abs;
  logic signed [60:0] rho_t;
  logic signed [15:0] el;
  logic signed [50:0] ws [3];

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = !q_empty && adv;

  // pose state, updated in queue order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        rot_r[i] <= (i % 4 == 0) ? ROT_ONE : '0;
      end
      for (int i = 0; i < 3; i++) begin
        tr_r[i] <= '0;
      end
    end else if (q_pop && q_item.kind == KIND_POSE) begin
      for (int i = 0; i < 9; i++) begin
        rot_r[i] <= q_item.rot[i*16 +: 16];
      end
      tr_r[0] <= q_item.pos_x;
      tr_r[1] <= q_item.pos_y;
      tr_r[2] <= q_item.pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      p5_v_r      <= 1'b0;
      p6_v_r      <= 1'b0;
      p7_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p0_v_r      <= q_pop && (q_item.kind == KIND_POINT);
      p1_v_r      <= p0_v_r;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      p4_v_r      <= p3_v_r;
      p5_v_r      <= p4_v_r;
      p6_v_r      <= c1_v;
      p7_v_r      <= p6_v_r;
      out_valid_r <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    min2_r <= cfg.range_lo * cfg.range_lo;
    max2_r <= cfg.range_hi * cfg.range_hi;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = p2_b_r[i][36] ? 36'(-p2_b_r[i]) : 36'(p2_b_r[i]);
      ws[i] = 51'(p1_prod_r[i*3]) + 51'(p1_prod_r[i*3+1]) + 51'(p1_prod_r[i*3+2])
              + 51'sd8192;
    end
    sq_sum = 74'({p3_hh_r[0], 36'd0}) + 74'({p3_hl_r[0], 19'd0}) + 74'(p3_ll_r[0])
           + 74'({p3_hh_r[1], 36'd0}) + 74'({p3_hl_r[1], 19'd0}) + 74'(p3_ll_r[1])
           + 74'({p3_hh_r[2], 36'd0}) + 74'({p3_hl_r[2], 19'd0}) + 74'(p3_ll_r[2]);
    range_ok = !(p4_sq_r < 74'(min2_r))
            && !((cfg.range_hi != '0) && (p4_sq_r > 74'(max2_r)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_d_r[0] <= 33'(q_item.pos_x) - 33'(tr_r[0]);
      p0_d_r[1] <= 33'(q_item.pos_y) - 33'(tr_r[1]);
      p0_d_r[2] <= 33'(q_item.pos_z) - 33'(tr_r[2]);
      p0_rot_r       <= rot_r;
      p0_side_r.pos_x <= q_item.pos_x;
      p0_side_r.pos_y <= q_item.pos_y;
      p0_side_r.pos_z <= q_item.pos_z;
      p0_side_r.last  <= q_item.last;
      p0_fin_r        <= q_item.finite;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1_prod_r[i*3+j] <= p0_rot_r[i*3+j] * p0_d_r[j];
        end
      end
      p1_side_r <= p0_side_r;
      p1_fin_r  <= p0_fin_r;

      for (int i = 0; i < 3; i++) begin
        p2_b_r[i] <= ws[i][50:14];
      end
      p2_side_r <= p1_side_r;
      p2_fin_r  <= p1_fin_r;

      for (int i = 0; i < 3; i++) begin
        p3_hh_r[i] <= u[i][35:18] * u[i][35:18];
        p3_hl_r[i] <= u[i][35:18] * u[i][17:0];
        p3_ll_r[i] <= u[i][17:0] * u[i][17:0];
      end
      p3_b_r    <= p2_b_r;
      p3_side_r <= p2_side_r;
      p3_fin_r  <= p2_fin_r;

      p4_sq_r   <= sq_sum;
      p4_b_r    <= p3_b_r;
      p4_side_r <= p3_side_r;
      p4_fin_r  <= p3_fin_r;

      p5_b_r    <= p4_b_r;
      p5_side_r <= p4_side_r;
      p5_keep_r <= p4_fin_r && range_ok;
    end
  end

  always_comb begin
    c1_t.keep = p5_keep_r;
    c1_t.bz   = p5_b_r[2];
    c1_t.side = p5_side_r;
  end
  assign c1_tag_in = c1_t;

  pcfc_cordic #(
    .W      (CW),
    .STAGES (CORDIC_STAGES),
    .AB     (ANGLE_BITS),
    .TW     ($bits(tag1_t))
  ) u_cordic_az (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p5_v_r),
    .in_x      (CW'(p5_b_r[0])),
    .in_y      (CW'(p5_b_r[1])),
    .in_tag    (c1_tag_in),
    .out_valid (c1_v),
    .out_mag   (c1_mag),
    .out_ang   (c1_ang),
    .out_tag   (c1_tag_out)
  );

  always_comb begin
    tag1_t t1;
    t1 = c1_tag_out;
    az = to_bin16(c1_ang) - cfg.az_center;
    az_x = 17'(az);
    az_abs = az_x[16] ? 17'(-az_x) : 17'(az_x);
    rho_t = p6_mp_r + (61'sd1 <<< 19);
    c2_t.keep = p7_keep_r;
    c2_t.side = p7_side_r;
    el = to_bin16(c2_ang);
    p6_bz_next = t1.bz;
    p6_side_next = t1.side;
    p6_keep_next = t1.keep && !(az_abs > 17'(cfg.half_fov_h));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_mp_r   <= 61'(c1_mag) * $signed({1'b0, INV_GAIN_Q20});
      p6_bz_r   <= p6_bz_next;
      p6_side_r <= p6_side_next;
      p6_keep_r <= p6_keep_next;

      p7_rho_r  <= CW'(rho_t >>> 20);
      p7_bz_r   <= p6_bz_r;
      p7_side_r <= p6_side_r;
      p7_keep_r <= p6_keep_r;
    end
  end

  assign c2_tag_in = c2_t;

  pcfc_cordic #(
    .W      (CW),
    .STAGES (CORDIC_STAGES),
    .AB     (ANGLE_BITS),
    .TW     ($bits(tag2_t))
  ) u_cordic_el (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p7_v_r),
    .in_x      (p7_rho_r),
    .in_y      (CW'(p7_bz_r)),
    .in_tag    (c2_tag_in),
    .out_valid (c2_v),
    .out_mag   (c2_mag),
    .out_ang   (c2_ang),
    .out_tag   (c2_tag_out)
  );

  always_ff @(posedge clk) begin
    tag2_t t2;
    t2 = c2_tag_out;
    if (adv) begin
      out_keep     <= t2.keep && !(el < cfg.elev_lo) && !(el > cfg.fov_up)
                      && (c2_mag == c2_mag);
      out_x        <= t2.side.pos_x;
      out_y        <= t2.side.pos_y;
      out_z        <= t2.side.pos_z;
      out_scan_end <= t2.side.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/point_cloud_fov_crop.sv =====
// top level of the lidar field-of-view and range crop filter
// depends on pcfc_pkg, pcfc_front, pcfc_queue, pcfc_back
//
// usage:
//   input channel (in_valid/in_stall): in_kind 0 loads a pose (quaternion and
//   translation) and yields no result; in_kind 1 is a point, which yields one
//   result with out_keep and the point passed through unchanged.
//   output channel (out_valid/out_stall): results appear in input order.
//   config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   only while no item is in flight.
// throughput: one item per cycle sustained while out_stall is low.
// path: from the accepting edge to out_valid an item passes the front
//   register, the queue, the transform and range stages and the two
//   chained cordic pipelines.
// stall: out_stall holds the back pipeline while out_valid is high; the front
//   register and a 4-entry queue take items until full, then in_stall rises.
// reset: synchronous, active low; pose is identity rotation and zero
//   translation, and the config registers take their reset values from pcfc_pkg.
`default_nettype none

module point_cloud_fov_crop
  import pcfc_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic signed [31:0]    in_pos_x,
  input  wire logic signed [31:0]    in_pos_y,
  input  wire logic signed [31:0]    in_pos_z,
  input  wire logic signed [15:0]    in_quat_w,
  input  wire logic signed [15:0]    in_quat_x,
  input  wire logic signed [15:0]    in_quat_y,
  input  wire logic signed [15:0]    in_quat_z,
  input  wire logic                  in_point_finite,
  input  wire logic                  in_last_in_scan,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_keep,
  output logic signed [31:0]         out_x,
  output logic signed [31:0]         out_y,
  output logic signed [31:0]         out_z,
  output logic                       out_scan_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t q_in;
  item_t q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_fov_h <= HALF_FOV_H_RST;
      cfg_r.fov_up     <= FOV_UP_RST;
      cfg_r.elev_lo    <= FOV_DOWN_RST;
      cfg_r.range_lo   <= MIN_RANGE_RST;
      cfg_r.range_hi   <= MAX_RANGE_RST;
      cfg_r.az_center  <= YAW_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_FOV_H: cfg_r.half_fov_h <= cfg_data[15:0];
        REG_FOV_UP:     cfg_r.fov_up     <= cfg_data[15:0];
        REG_FOV_DOWN:   cfg_r.elev_lo    <= cfg_data[15:0];
        REG_MIN_RANGE:  cfg_r.range_lo   <= cfg_data;
        REG_MAX_RANGE:  cfg_r.range_hi   <= cfg_data;
        REG_YAW_OFFSET: cfg_r.az_center  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pcfc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_quat_w       (in_quat_w),
    .in_quat_x       (in_quat_x),
    .in_quat_y       (in_quat_y),
    .in_quat_z       (in_quat_z),
    .in_point_finite (in_point_finite),
    .in_last_in_scan (in_last_in_scan),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_in)
  );

  pcfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  pcfc_back #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_keep     (out_keep),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_scan_end (out_scan_end)
  );

endmodule

`default_nettype wire
